// ===== rtl/elbl_pkg.sv =====
// Shared constants and codes for the extent list block lookup.
package elbl_pkg;

    localparam int MAX_EXTENTS = 256;
    localparam int ADDR_W      = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int BLK_W       = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef logic [BLK_W-1:0] t_blk;

endpackage

// ===== rtl/extent_list_block_lookup.sv =====
// Extent list lookup: maps a logical block index to a physical block number.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------------------
//  request  | i_valid / o_ready  | i_action, i_first_block, i_block_count,
//           |                    | i_block_index
//  result   | o_valid / i_ready  | o_status, o_data_block
//
// A clear or an append gives its result in the cycle after its transfer.
// A lookup walks the stored extents in order from the first until the index falls in one
// or the list ends; the extent memory has one read port and yields one extent a cycle.
// One request is worked on at a time; o_ready is high when the walker is idle and
// the result register is empty or being emptied. A stalled result holds its value.
// Reset empties the list and the result register; extent memory contents are kept.
module extent_list_block_lookup (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  elbl_pkg::t_blk    i_first_block,
    input  elbl_pkg::t_blk    i_block_count,
    input  elbl_pkg::t_blk    i_block_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output elbl_pkg::t_blk    o_data_block
);
    import elbl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_blk              r_ext_start  [MAX_EXTENTS];
    t_blk              r_ext_length [MAX_EXTENTS];

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_idx;
    t_blk              r_rem;
    t_blk              r_rd_start;
    t_blk              r_rd_length;
    logic              r_out_valid;
    logic [1:0]        r_status;
    t_blk              r_data;

    logic              accept;
    logic              out_free;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              hit;
    logic              last;
    logic [CNT_W-1:0]  idx_next;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_data_block = r_data;

    assign wr_en = accept && (i_action == ACT_APPEND) && (i_first_block != '0)
                   && (r_count < CNT_W'(MAX_EXTENTS));

    assign hit      = r_rem < r_rd_length;
    assign idx_next = {1'b0, r_idx} + CNT_W'(1);
    assign last     = idx_next == r_count;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept && (i_action == ACT_LOOKUP)) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (r_state == S_WALK && !hit && !last) begin
            rd_en   = 1'b1;
            rd_addr = idx_next[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ext_start[r_count[ADDR_W-1:0]]  <= i_first_block;
            r_ext_length[r_count[ADDR_W-1:0]] <= i_block_count;
        end
        if (rd_en) begin
            r_rd_start  <= r_ext_start[rd_addr];
            r_rd_length <= r_ext_length[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_action)
                            ACT_CLEAR: begin
                                r_count     <= '0;
                                r_status    <= ST_OK;
                                r_data      <= '0;
                                r_out_valid <= 1'b1;
                            end
                            ACT_APPEND: begin
                                if (wr_en) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                                r_status    <= (wr_en || i_first_block == '0) ? ST_OK
                                                                               : ST_FULL;
                                r_data      <= '0;
                                r_out_valid <= 1'b1;
                            end
                            ACT_LOOKUP: begin
                                if (r_count == '0) begin
                                    r_status    <= ST_NOT_FOUND;
                                    r_data      <= '0;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_idx       <= '0;
                                    r_rem       <= i_block_index;
                                    r_out_valid <= 1'b0;
                                    r_state     <= S_WALK;
                                end
                            end
                            default: begin
                                r_status    <= ST_OK;
                                r_data      <= '0;
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (hit) begin
                        r_status    <= ST_OK;
                        r_data      <= r_rd_start + r_rem;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (last) begin
                        r_status    <= ST_NOT_FOUND;
                        r_data      <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_rem <= r_rem - r_rd_length;
                        r_idx <= idx_next[ADDR_W-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_EXTENTS))
        else $error("Extent count exceeds the list capacity.");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ({1'b0, r_idx} < r_count))
        else $error("Walk index has passed the stored extents.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_data == '0))
        else $error("Failed result carries a non-zero block number.");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Stored append did not advance the extent count.");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !accept)
        else $error("Request transfer taken while a lookup is in progress.");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the extent list block lookup.
module tb;
    import elbl_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = MAX_EXTENTS + 44;
    localparam int STALL_LIMIT   = 4000;
    localparam int ITEM_TARGET   = 1850;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [1:0] status;
        t_blk       block;
    } t_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_action = ACT_CLEAR;
    t_blk       i_first_block = '0;
    t_blk       i_block_count = '0;
    t_blk       i_block_index = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_status;
    t_blk       o_data_block;

    t_blk    ext_first [MAX_EXTENTS];
    t_blk    ext_len [MAX_EXTENTS];
    int      ext_used = 0;
    t_answer awaited_answers [$];

    int sent_items = 0;
    int hits = 0;
    int misses = 0;
    int refusals = 0;
    int mismatches = 0;
    int files = 0;
    int idle_cycles = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_results = 1'b0;

    extent_list_block_lookup uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_first_block(i_first_block),
        .i_block_count(i_block_count),
        .i_block_index(i_block_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_data_block (o_data_block)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_answer map_request(input logic [1:0] act, input t_blk first,
                                            input t_blk count, input t_blk index);
        t_answer ans;
        t_blk    rest;
        bit      hit;
        ans.status = ST_OK;
        ans.block  = '0;
        case (act)
            ACT_CLEAR: begin
                ext_used = 0;
            end
            ACT_APPEND: begin
                if (first != '0) begin
                    if (ext_used >= MAX_EXTENTS) begin
                        ans.status = ST_FULL;
                        refusals++;
                    end else begin
                        ext_first[ext_used] = first;
                        ext_len[ext_used]   = count;
                        ext_used++;
                    end
                end
            end
            ACT_LOOKUP: begin
                rest = index;
                hit  = 1'b0;
                for (int k = 0; k < ext_used && !hit; k++) begin
                    if (rest < ext_len[k]) begin
                        ans.block = ext_first[k] + rest;
                        hit = 1'b1;
                    end else begin
                        rest -= ext_len[k];
                    end
                end
                if (hit) begin
                    hits++;
                end else begin
                    ans.status = ST_NOT_FOUND;
                    misses++;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic send_request(input logic [1:0] act, input t_blk first, input t_blk count,
                                input t_blk index);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_first_block <= first;
        i_block_count <= count;
        i_block_index <= index;
        do @(posedge i_clk); while (!o_ready);
        awaited_answers.push_back(map_request(act, first, count, index));
        sent_items++;
    endtask

    task automatic note_mismatch(input string what, input t_blk want, input t_blk got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("Wrong %s: expected %h, got %h", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Run stalled with %0d results outstanding.", awaited_answers.size());
                $display("extent_list_block_lookup: mismatch");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (awaited_answers.size() == 0) begin
                    note_mismatch("unexpected result", '0, o_data_block);
                end else begin
                    want = awaited_answers.pop_front();
                    if (o_status !== want.status) begin
                        note_mismatch("status", t_blk'(want.status), t_blk'(o_status));
                    end
                    if (o_data_block !== want.block) begin
                        note_mismatch("data block", want.block, o_data_block);
                    end
                end
            end
        end
    end

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_results) begin
                gap = HOLD_CYCLES;
                hold_results = 1'b0;
            end else begin
                gap = rx_idle ? $urandom_range(0, 15) : 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic test_empty_list;
        send_request(ACT_LOOKUP, $urandom, $urandom, '0);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'hFFFF_FFFF);
    endtask

    task automatic test_ignored_append;
        send_request(ACT_APPEND, '0, 32'd5, $urandom);
        send_request(ACT_LOOKUP, $urandom, $urandom, '0);
    endtask

    task automatic test_address_wrap;
        send_request(ACT_CLEAR, $urandom, $urandom, $urandom);
        send_request(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
        send_request(ACT_LOOKUP, $urandom, $urandom, '0);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'd1);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'hFFFF_FFFE);
    endtask

    task automatic test_zero_length;
        send_request(ACT_CLEAR, $urandom, $urandom, $urandom);
        send_request(ACT_APPEND, 32'd5, '0, $urandom);
        send_request(ACT_APPEND, 32'd100, 32'd10, $urandom);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'd3);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'd9);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'd10);
    endtask

    task automatic test_spare_action;
        send_request(ACT_SPARE, $urandom, $urandom, $urandom);
        send_request(ACT_LOOKUP, $urandom, $urandom, 32'd3);
    endtask

    task automatic test_clear;
        send_request(ACT_CLEAR, $urandom, $urandom, $urandom);
        send_request(ACT_LOOKUP, $urandom, $urandom, '0);
    endtask

    task automatic test_full_list;
        t_blk total;
        t_blk count;
        total = '0;
        send_request(ACT_CLEAR, $urandom, $urandom, $urandom);
        repeat (MAX_EXTENTS) begin
            count = $urandom_range(0, 3);
            total += count;
            send_request(ACT_APPEND, $urandom | 32'h1, count, $urandom);
        end
        send_request(ACT_LOOKUP, $urandom, $urandom, total - 1);
        send_request(ACT_LOOKUP, $urandom, $urandom, total);
        send_request(ACT_APPEND, $urandom | 32'h1, $urandom, $urandom);
        send_request(ACT_APPEND, '0, $urandom, $urandom);
    endtask

    task automatic test_random_files;
        int   n_ext;
        int   pick;
        int   j;
        t_blk first;
        t_blk count;
        t_blk index;
        while (sent_items < ITEM_TARGET) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (files == 5) begin
                hold_results = 1'b1;
            end
            if ($urandom_range(0, 7) != 0) begin
                send_request(ACT_CLEAR, $urandom, $urandom, $urandom);
            end
            n_ext = ($urandom_range(0, 24) == 0) ? $urandom_range(120, 260)
                                                 : $urandom_range(1, 12);
            repeat (n_ext) begin
                case ($urandom_range(0, 9))
                    0: first = '0;
                    1: first = 32'hFFFF_FFFF - $urandom_range(0, 15);
                    default: first = $urandom;
                endcase
                case ($urandom_range(0, 9))
                    0: count = '0;
                    1: count = $urandom;
                    2: count = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: count = $urandom_range(1, 64);
                endcase
                send_request(ACT_APPEND, first, count, $urandom);
            end
            repeat ($urandom_range(2, 10)) begin
                pick  = $urandom_range(0, 19);
                index = $urandom;
                if (pick < 14 && ext_used > 0) begin
                    j = $urandom_range(0, ext_used - 1);
                    index = '0;
                    for (int k = 0; k < j; k++) index += ext_len[k];
                    if (ext_len[j] != '0) index += $urandom % ext_len[j];
                end else if (pick < 17) begin
                    index = '0;
                    for (int k = 0; k < ext_used; k++) index += ext_len[k];
                end
                if (pick == 19) begin
                    send_request(ACT_SPARE, $urandom, $urandom, $urandom);
                end else begin
                    send_request(ACT_LOOKUP, $urandom, $urandom, index);
                end
            end
            files++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list;
        test_ignored_append;
        test_address_wrap;
        test_zero_length;
        test_spare_action;
        test_clear;
        test_full_list;
        test_random_files;
        i_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests in %0d random files; %0d lookups hit, %0d missed.",
                 sent_items, files, hits, misses);
        $display("%0d appends refused on a full list; %0d mismatches seen.",
                 refusals, mismatches);
        if (mismatches == 0 && awaited_answers.size() == 0) begin
            $display("extent_list_block_lookup: match");
        end else begin
            $display("extent_list_block_lookup: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/elbl_pkg.sv
rtl/extent_list_block_lookup.sv
test/tb.sv
